[src/bia_pkg.sv]
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types and codes of the bitmap ID allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BitIdxW = 5;
  localparam int unsigned IdW = 11;
  localparam int unsigned StatusW = 2;

  // request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] ST_DONE = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL = 2'd1;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd2;

  // lowest clear bit of one map word
  typedef struct packed {
    logic               found;
    logic [BitIdxW-1:0] idx;
  } ffz_res_t;

endpackage

[src/bia_map_ram.sv]
// ----------------------------------------------------------------------------
// bia_map_ram
// Used-ID bitmap storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bia_map_ram
  import bia_pkg::*;
#(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WordW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [WordW-1:0] rd_data_o
);

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/bia_ffz.sv]
// ----------------------------------------------------------------------------
// bia_ffz
// Find-first-zero: locates the lowest clear bit of a 32-bit map word.
// ----------------------------------------------------------------------------
module bia_ffz
  import bia_pkg::*;
(
  input  logic [WordW-1:0] word_i,
  output ffz_res_t         res_o
);

  always_comb begin
    res_o.found = 1'b0;
    res_o.idx   = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        res_o.found = 1'b1;
        res_o.idx   = BitIdxW'(i);
      end
    end
  end

endmodule

[src/bitmap_id_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// First-free ID allocator over a bitmap of 32-bit words held in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): req_type_i selects allocate (lowest
//   free ID) or release (release_id_i). Every request yields one result on the
//   output channel (out_valid_o/out_ready_i): granted_id_o and status_o
//   (done, no free ID, or release ID out of range).
//   One request is in flight at a time. A release, or an allocate that lands
//   in the word under the scan pointer, does one RAM read, then modify and
//   write back. An allocate reads one more word for each full word it steps
//   over; the scan pointer only moves forward on allocates and is pulled back
//   by releases, so an allocate usually steps over none.
//   After reset ID 1 is taken and all others are free. No clearing pass is
//   run: a high-water mark tells which words have been written, and words
//   above it read as their reset value. Requests are taken right after reset.
//   The result sits in an output register; when the receiver stalls, the
//   next request is still taken and its read issued, and it waits in the
//   write-back cycle until the output register frees up.
// ----------------------------------------------------------------------------
module bitmap_id_allocator
  import bia_pkg::*;
#(
  parameter int unsigned ID_COUNT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [IdW-1:0]     release_id_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IdW-1:0]     granted_id_o,
  output logic [StatusW-1:0] status_o
);

  localparam int unsigned Words = (ID_COUNT + 31) / 32;
  localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned PtrW = $clog2(Words + 1);
  localparam int unsigned LastBits = ID_COUNT - (Words - 1) * 32;
  // bits of the last word beyond ID_COUNT always look used
  localparam logic [WordW-1:0] PadMask = WordW'(~((33'd1 << LastBits) - 33'd1));
  localparam logic [PtrW-1:0] WordsP = PtrW'(Words);
  localparam logic [PtrW-1:0] LastP = PtrW'(Words - 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_RELEASE,
    OP_FULL,
    OP_RANGE
  } op_e;

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [PtrW-1:0]    hint_q, hint_d;   // all words below are full
  logic [PtrW-1:0]    hw_q, hw_d;       // words below have been written
  logic [AddrW-1:0]   addr_q, addr_d;
  logic [BitIdxW-1:0] bit_q, bit_d;
  logic               out_valid_q, out_valid_d;
  logic [IdW-1:0]     granted_q, granted_d;
  logic [StatusW-1:0] status_q, status_d;

  logic               rd_en, wr_en;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic [WordW-1:0]   rd_data, wr_data;

  logic [WordW-1:0]   alloc_base, alloc_word, rel_cur;
  logic [PtrW-1:0]    hint_inc, addr_p;
  ffz_res_t           ffz;
  logic [IdW-1:0]     rel_m1;
  logic [AddrW-1:0]   rel_addr;
  logic               rel_bad, out_free;
  logic [31:0]        alloc_id;

  bia_map_ram #(
    .Depth(Words),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  bia_ffz u_ffz (
    .word_i(alloc_word),
    .res_o (ffz)
  );

  // word under the scan pointer, unwritten words read as reset value
  assign alloc_base = (hint_q < hw_q) ? rd_data : {{(WordW-1){1'b0}}, hint_q == '0};
  assign alloc_word = alloc_base | ((hint_q == LastP) ? PadMask : '0);
  assign hint_inc   = hint_q + 1'b1;
  assign alloc_id   = 32'({hint_q, ffz.idx}) + 32'd1;

  assign addr_p  = PtrW'(addr_q);
  assign rel_cur = (addr_p < hw_q) ? rd_data : {{(WordW-1){1'b0}}, addr_q == '0};

  assign rel_m1   = release_id_i - 1'b1;
  assign rel_addr = AddrW'(rel_m1[IdW-1:BitIdxW]);
  assign rel_bad  = (release_id_i == '0) || (32'(release_id_i) > ID_COUNT);

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    hint_d      = hint_q;
    hw_d        = hw_q;
    addr_d      = addr_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    granted_d   = granted_q;
    status_d    = status_q;
    rd_en       = 1'b0;
    rd_addr     = hint_q[AddrW-1:0];
    wr_en       = 1'b0;
    wr_addr     = addr_q;
    wr_data     = rel_cur & ~(WordW'(1) << bit_q);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
          if (req_type_i == REQ_ALLOC) begin
            if (hint_q == WordsP) begin
              op_d = OP_FULL;
            end else begin
              op_d  = OP_ALLOC;
              rd_en = 1'b1;
            end
          end else if (rel_bad) begin
            op_d = OP_RANGE;
          end else begin
            op_d    = OP_RELEASE;
            rd_en   = 1'b1;
            rd_addr = rel_addr;
            addr_d  = rel_addr;
            bit_d   = rel_m1[BitIdxW-1:0];
          end
        end
      end
      S_EXEC: begin
        case (op_q)
          OP_ALLOC: begin
            if (!ffz.found) begin
              // word full: step the scan pointer and read the next word
              hint_d = hint_inc;
              if (hint_inc == WordsP) begin
                op_d = OP_FULL;
              end else begin
                rd_en   = 1'b1;
                rd_addr = hint_inc[AddrW-1:0];
              end
            end else if (out_free) begin
              wr_en   = 1'b1;
              wr_addr = hint_q[AddrW-1:0];
              wr_data = alloc_base | (WordW'(1) << ffz.idx);
              if (hint_q == hw_q) begin
                hw_d = hw_q + 1'b1;
              end
              out_valid_d = 1'b1;
              granted_d   = alloc_id[IdW-1:0];
              status_d    = ST_DONE;
              state_d     = S_IDLE;
            end
          end
          OP_RELEASE: begin
            if (out_free) begin
              // words above the mark are still all clear: nothing to write
              if (addr_p <= hw_q) begin
                wr_en = 1'b1;
              end
              if (addr_p == hw_q) begin
                hw_d = hw_q + 1'b1;
              end
              if (addr_p < hint_q) begin
                hint_d = addr_p;
              end
              out_valid_d = 1'b1;
              granted_d   = '0;
              status_d    = ST_DONE;
              state_d     = S_IDLE;
            end
          end
          OP_FULL: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              granted_d   = '0;
              status_d    = ST_FULL;
              state_d     = S_IDLE;
            end
          end
          OP_RANGE: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              granted_d   = '0;
              status_d    = ST_RANGE;
              state_d     = S_IDLE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ALLOC;
      hint_q      <= '0;
      hw_q        <= '0;
      addr_q      <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      granted_q   <= '0;
      status_q    <= ST_DONE;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      hint_q      <= hint_d;
      hw_q        <= hw_d;
      addr_q      <= addr_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
      granted_q   <= granted_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign granted_id_o = granted_q;
  assign status_o     = status_q;

endmodule

[src/bia_checker.sv]
// ----------------------------------------------------------------------------
// bia_checker
// Port-level checks of the bitmap ID allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bia_checker
  import bia_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [IdW-1:0]     granted_id_o,
  input logic [StatusW-1:0] status_o
);

  // one request in flight: no transfer in the cycle after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a request is in flight");

  // only a successful allocate carries an ID
  a_no_id_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_DONE |-> granted_id_o == '0)
    else $error("nonzero ID on a failed request");

  // a new result comes only out of the execute state (input not ready)
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a request being worked on");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(granted_id_o) && $stable(status_o))
    else $error("stalled result changed");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .granted_id_o(granted_id_o),
  .status_o    (status_o)
);

[tb/bitmap_id_allocator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator_test
// Self-checking bench for the bitmap ID allocator. Requests go in through a
// queue-fed driver with random gaps, results are checked in order against a
// shadow copy of the ID bitmap. The run fills the map to exhaustion, then mixes
// allocates and releases, and ends on a release-heavy mix.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_test;
  import bia_pkg::*;

  localparam int unsigned NumIds = 1024;
  localparam int unsigned NumWords = (NumIds + WordW - 1) / WordW;
  localparam int unsigned MaxShown = 10;

  typedef struct packed {
    logic           kind;
    logic [IdW-1:0] rel_id;
  } request_t;

  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [StatusW-1:0] st;
  } grant_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               req_type_i;
  logic [IdW-1:0]     release_id_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [IdW-1:0]     granted_id_o;
  logic [StatusW-1:0] status_o;

  bitmap_id_allocator #(
    .ID_COUNT(NumIds)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .release_id_i(release_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .granted_id_o(granted_id_o),
    .status_o    (status_o)
  );

  // shadow of the allocator's bitmap
  logic [WordW-1:0] taken_map [NumWords];

  request_t request_q [$];
  grant_t   expected_grants [$];

  logic in_taken;
  logic no_idle;
  int   send_gap;
  int   recv_stall;
  int   mismatches;
  int   n_requests, n_granted, n_full, n_released, n_range;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Mirrors one request on the shadow map and returns the result it owes.
  function automatic grant_t alloc_or_release(request_t rq);
    grant_t     g;
    logic [9:0] pos;
    int unsigned id;
    logic       done;
    g.id = '0;
    g.st = ST_DONE;
    done = 1'b0;
    n_requests++;
    if (rq.kind == REQ_ALLOC) begin
      for (int w = 0; w < NumWords && !done; w++) begin
        if (taken_map[w] != 32'hFFFF_FFFF) begin
          for (int b = 0; b < WordW && !done; b++) begin
            id = w * WordW + b + 1;
            if (id > NumIds) begin
              done = 1'b1;
            end else if (!taken_map[w][b]) begin
              taken_map[w][b] = 1'b1;
              g.id = id[IdW-1:0];
              done = 1'b1;
            end
          end
        end
      end
      if (g.id == '0) begin
        g.st = ST_FULL;
        n_full++;
      end else begin
        n_granted++;
      end
    end else if (rq.rel_id == '0 || rq.rel_id > NumIds) begin
      g.st = ST_RANGE;
      n_range++;
    end else begin
      pos = 10'(rq.rel_id - 1);
      taken_map[pos / WordW][pos % WordW] = 1'b0;
      n_released++;
    end
    return g;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // A random ID that is currently held, found by a scan from a random start; any in-range ID if none is held.
  function automatic logic [IdW-1:0] pick_taken_id();
    int unsigned start, p;
    start = $urandom_range(0, NumIds - 1);
    for (int k = 0; k < NumIds; k++) begin
      p = (start + k) % NumIds;
      if (taken_map[p / WordW][p % WordW]) return IdW'(p + 1);
    end
    return IdW'($urandom_range(1, NumIds));
  endfunction

  // driver
  always @(negedge clk_i) begin : drive
    request_t rq;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      in_taken <= 1'b0;
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (request_q.size() > 0) begin
        rq = request_q.pop_front();
        req_type_i <= rq.kind;
        release_id_i <= rq.rel_id;
        in_valid_i <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < 25) recv_stall = pick_gap();
      end
    end
  end

  // monitor: check the result first, then record the transfer in
  always @(posedge clk_i) begin : monitor
    grant_t exp_g;
    if (out_valid_o && out_ready_i) begin
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("ERROR: unexpected result id=%0d status=%0d", granted_id_o, status_o);
      end else begin
        exp_g = expected_grants.pop_front();
        if (granted_id_o !== exp_g.id || status_o !== exp_g.st) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("ERROR: expected id=%0d status=%0d, got id=%0d status=%0d",
                     exp_g.id, exp_g.st, granted_id_o, status_o);
        end
      end
    end
    if (in_valid_i && in_ready_o) begin
      expected_grants.push_back(alloc_or_release('{kind: req_type_i, rel_id: release_id_i}));
      in_taken <= 1'b1;
    end
  end

  task automatic send(logic kind, logic [IdW-1:0] rel_id);
    request_q.push_back('{kind: kind, rel_id: rel_id});
    // keep the queue short so picks from the shadow map stay current
    while (request_q.size() > 1) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid_i || expected_grants.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic send_random(int count, int alloc_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        send(REQ_ALLOC, IdW'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) send(REQ_RELEASE, pick_taken_id());
        else if (r < 88) send(REQ_RELEASE, IdW'($urandom_range(1, NumIds)));
        else send(REQ_RELEASE, IdW'($urandom));
      end
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = REQ_ALLOC;
    release_id_i = '0;
    out_ready_i = 1'b0;
    in_taken = 1'b0;
    no_idle = 1'b0;
    send_gap = 0;
    recv_stall = 0;
    mismatches = 0;
    n_requests = 0;
    n_granted = 0;
    n_full = 0;
    n_released = 0;
    n_range = 0;
    for (int w = 0; w < NumWords; w++) taken_map[w] = '0;
    taken_map[0][0] = 1'b1;  // ID 1 is held out of reset
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // out-of-range releases, edges of the ID field, release and reallocation of low IDs
    send(REQ_RELEASE, '0);
    send(REQ_RELEASE, '1);
    send(REQ_RELEASE, IdW'(NumIds + 1));
    send(REQ_RELEASE, IdW'(NumIds));  // already free
    send(REQ_ALLOC, '0);
    send(REQ_ALLOC, '1);
    send(REQ_RELEASE, IdW'(1));  // frees the ID reserved at reset
    send(REQ_ALLOC, '0);
    send(REQ_ALLOC, '0);
    send(REQ_RELEASE, IdW'(3));
    send(REQ_RELEASE, IdW'(3));
    send(REQ_ALLOC, '0);
    wait_drained();

    // fill the map until allocation is refused
    send_random(1030, 100);
    wait_drained();

    // top ID, full refusal, word boundary
    send(REQ_RELEASE, IdW'(NumIds));
    send(REQ_ALLOC, '0);
    send(REQ_ALLOC, '0);
    send(REQ_RELEASE, IdW'(32));
    send(REQ_RELEASE, IdW'(33));
    send(REQ_ALLOC, '0);
    send(REQ_ALLOC, '0);
    send(REQ_ALLOC, '0);
    wait_drained();

    send_random(40, 50);
    no_idle = 1'b1;
    send_random(40, 50);
    wait_drained();
    no_idle = 1'b0;
    send_random(60, 20);
    wait_drained();

    repeat (40) @(posedge clk_i);
    mismatches += expected_grants.size();
    $display("Covered %0d requests: %0d grants, %0d full refusals,", n_requests, n_granted,
             n_full);
    $display("  %0d releases, %0d out-of-range releases; %0d mismatches", n_released,
             n_range, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TIMEOUT");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[bitmap_id_allocator.f]
src/bia_pkg.sv
src/bia_map_ram.sv
src/bia_ffz.sv
src/bitmap_id_allocator.sv
src/bia_checker.sv
tb/bitmap_id_allocator_test.sv
